// ===== rtl/core/base64_stream_encoder_top_defines.svh =====
// Assertion macros shared by the base64 stream encoder RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BASE64_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE64_STREAM_ENCODER_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define B64E_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define B64E_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/core/b64e_pkg.sv =====
// Package for the base64 stream encoder: character constants, alphabet lookup,
// group phase codes and the queue entry type passed from front to back. No dependencies.
package b64e_pkg;

    localparam int unsigned QDepth = 2;
    localparam int unsigned QPtrW  = $clog2(QDepth);

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] UPPER_BASE = 8'h41;
    localparam logic [7:0] LOWER_BASE = 8'h61;
    localparam logic [7:0] DIGIT_BASE = 8'h30;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } phase_t;

    // One accepted byte: up to four characters, last_idx = count - 1.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } entry_t;

    function automatic logic [7:0] sym(input logic [5:0] idx);
        logic [7:0] ch;
        case (idx) inside
            [6'd0:6'd25]:  ch = UPPER_BASE + {2'b00, idx};
            [6'd26:6'd51]: ch = LOWER_BASE + {2'b00, idx} - 8'd26;
            [6'd52:6'd61]: ch = DIGIT_BASE + {2'b00, idx} - 8'd52;
            6'd62:         ch = PLUS_CHAR;
            default:       ch = SLASH_CHAR;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/b64e_front.sv =====
// Front part: accepts bytes, tracks group position and carried bits, and builds
// one queue entry per byte. Depends on b64e_pkg.
module b64e_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [7:0] data_byte
    input  logic              s_tlast,
    input  logic              push_ready,
    output logic              push,
    output b64e_pkg::entry_t  push_entry
);

    b64e_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       carry_reg, carry_next;

    assign s_tready = push_ready;
    assign push     = s_tvalid & push_ready;

    always_comb begin
        push_entry          = '0;
        push_entry.fin      = s_tlast;
        phase_next          = phase_reg;
        carry_next          = carry_reg;
        case (phase_reg)
            b64e_pkg::PH_SECOND: begin
                push_entry.chars[0] = b64e_pkg::sym({carry_reg[1:0], s_tdata[7:4]});
                if (s_tlast) begin
                    push_entry.chars[1] = b64e_pkg::sym({s_tdata[3:0], 2'b00});
                    push_entry.chars[2] = b64e_pkg::PAD_CHAR;
                    push_entry.last_idx = 2'd2;
                    phase_next          = b64e_pkg::PH_FIRST;
                    carry_next          = 4'd0;
                end else begin
                    push_entry.last_idx = 2'd0;
                    phase_next          = b64e_pkg::PH_THIRD;
                    carry_next          = s_tdata[3:0];
                end
            end
            b64e_pkg::PH_THIRD: begin
                push_entry.chars[0] = b64e_pkg::sym({carry_reg, s_tdata[7:6]});
                push_entry.chars[1] = b64e_pkg::sym(s_tdata[5:0]);
                push_entry.last_idx = 2'd1;
                phase_next          = b64e_pkg::PH_FIRST;
                carry_next          = 4'd0;
            end
            default: begin
                push_entry.chars[0] = b64e_pkg::sym(s_tdata[7:2]);
                if (s_tlast) begin
                    push_entry.chars[1] = b64e_pkg::sym({s_tdata[1:0], 4'b0000});
                    push_entry.chars[2] = b64e_pkg::PAD_CHAR;
                    push_entry.chars[3] = b64e_pkg::PAD_CHAR;
                    push_entry.last_idx = 2'd3;
                    phase_next          = b64e_pkg::PH_FIRST;
                    carry_next          = 4'd0;
                end else begin
                    push_entry.last_idx = 2'd0;
                    phase_next          = b64e_pkg::PH_SECOND;
                    carry_next          = {2'b00, s_tdata[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= b64e_pkg::PH_FIRST;
            carry_reg <= 4'd0;
        end else if (push) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

// ===== rtl/core/b64e_queue.sv =====
// Short FIFO of entries between front and back parts.
// Depends on b64e_pkg.
module b64e_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  b64e_pkg::entry_t  push_entry,
    output logic              push_ready,
    input  logic              pop,
    output logic              head_valid,
    output b64e_pkg::entry_t  head_entry
);

    localparam int unsigned CntW = $clog2(b64e_pkg::QDepth + 1);

    b64e_pkg::entry_t                 mem [b64e_pkg::QDepth];
    logic [b64e_pkg::QPtrW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]                  count_reg, count_next;

    assign push_ready = (count_reg != CntW'(b64e_pkg::QDepth));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == b64e_pkg::QPtrW'(b64e_pkg::QDepth - 1))
                              ? '0 : wr_ptr_reg + b64e_pkg::QPtrW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == b64e_pkg::QPtrW'(b64e_pkg::QDepth - 1))
                              ? '0 : rd_ptr_reg + b64e_pkg::QPtrW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/b64e_back.sv =====
// Back part: moves head entry characters, one per cycle unless stalled, into the
// output register. Depends on b64e_pkg and base64_stream_encoder_top_defines.svh.
`include "base64_stream_encoder_top_defines.svh"

module b64e_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  b64e_pkg::entry_t  head_entry,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,    // [7:0] out_char
    output logic              m_tlast
);

    logic [1:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       load;
    logic       at_end;

    assign load     = !valid_reg || m_tready;
    assign at_end   = (pos_reg == head_entry.last_idx);
    assign pop      = load && head_valid && at_end;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                pos_next = at_end ? 2'd0 : pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && head_valid) begin
            data_reg <= head_entry.chars[pos_reg];
            last_reg <= head_entry.fin && at_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    `B64E_NEVER(a_pos_in_range, aclk, aresetn,
        head_valid && (pos_reg > head_entry.last_idx), "char position past end of entry")
    `B64E_ASSERT(a_pos_idle_zero, aclk, aresetn,
        !head_valid |-> (pos_reg == 2'd0), "char position nonzero with empty queue")
    `B64E_ASSERT(a_first_not_pad, aclk, aresetn,
        (load && head_valid && pos_reg == 2'd0) |=> (data_reg != b64e_pkg::PAD_CHAR),
        "padding emitted as first char of a byte")

endmodule

// ===== rtl/core/base64_stream_encoder_top.sv =====
// Top level of the base64 stream encoder (standard alphabet, '=' padding).
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Takes one message byte per input item and returns its Base64 text, one ASCII character per
// output item, with tlast on the final character of the message. A byte gives one character
// at group position 0 or 1 and two at position 2; the last byte of a message also flushes the
// group with '=' padding (four characters in all from position 0, three from position 1).
// Input bytes are accepted one per cycle while the two-entry queue has room; the output
// register moves one character per cycle unless the sink holds m_tready low. On an empty
// pipeline the first character of a byte is registered in the queue entry and then in the
// output register before it is presented on the output.
module base64_stream_encoder_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_char
    output logic       m_tlast
);

    logic             push, push_ready, pop, head_valid;
    b64e_pkg::entry_t push_entry, head_entry;

    b64e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_ready (push_ready),
        .push       (push),
        .push_entry (push_entry)
    );

    b64e_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    b64e_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== bench/tb_base64_stream_encoder_top.sv =====
// Self-checking testbench for base64_stream_encoder_top: byte messages in, Base64 text out,
// checked character by character against an encoder model kept in the bench.
// Depends on b64e_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_base64_stream_encoder_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [0:63][7:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef enum logic [2:0] {
        GRP_FIRST  = 3'b001,
        GRP_SECOND = 3'b010,
        GRP_THIRD  = 3'b100
    } grp_pos_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } b64_char_t;

    typedef logic [7:0] msg_t [$];

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_char
    logic       m_tlast;

    grp_pos_t   grp_pos   = GRP_FIRST;
    logic [3:0] carry     = 4'h0;
    b64_char_t  pending_text [$];
    b64_char_t  want;
    int         mismatches = 0;
    int         cycles     = 0;
    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;

    base64_stream_encoder_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        return ALPHABET[idx];
    endfunction

    function automatic void push_char(input logic [7:0] ch, input logic last);
        b64_char_t c;
        c.ch   = ch;
        c.last = last;
        pending_text = {pending_text, c};
    endfunction

    // Expected text for one accepted byte; updates the group position and leftover bits.
    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        case (grp_pos)
            GRP_SECOND: begin
                push_char(b64_char({carry[1:0], b[7:4]}), 1'b0);
                if (fin) begin
                    push_char(b64_char({b[3:0], 2'b00}), 1'b0);
                    push_char(b64e_pkg::PAD_CHAR, 1'b1);
                    grp_pos = GRP_FIRST;
                    carry   = 4'h0;
                end else begin
                    grp_pos = GRP_THIRD;
                    carry   = b[3:0];
                end
            end
            GRP_THIRD: begin
                push_char(b64_char({carry, b[7:6]}), 1'b0);
                push_char(b64_char(b[5:0]), fin);
                grp_pos = GRP_FIRST;
                carry   = 4'h0;
            end
            default: begin
                push_char(b64_char(b[7:2]), 1'b0);
                if (fin) begin
                    push_char(b64_char({b[1:0], 4'h0}), 1'b0);
                    push_char(b64e_pkg::PAD_CHAR, 1'b0);
                    push_char(b64e_pkg::PAD_CHAR, 1'b1);
                    grp_pos = GRP_FIRST;
                    carry   = 4'h0;
                end else begin
                    grp_pos = GRP_SECOND;
                    carry   = {2'b00, b[1:0]};
                end
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        encode_byte(b, fin);
    endtask

    task automatic send_msg(input msg_t msg);
        foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    endtask

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    // Random messages of 1..9 bytes, sometimes 10..20, so every group position ends a message.
    task automatic send_random_msgs(input int n_bytes);
        msg_t msg;
        int   sent;
        int   len;
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(20, 10) : $urandom_range(9, 1);
            msg.delete();
            repeat (len) msg = {msg, rand_byte()};
            send_msg(msg);
            sent += len;
        end
    endtask

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_msg('{8'h00});
        send_msg('{8'hFF});
        send_msg('{8'hFF, 8'hFF});
        send_msg('{8'h00, 8'h00, 8'h00});
        send_msg('{8'hFB, 8'hEF, 8'hBE, 8'hFF, 8'hFF, 8'hFF, 8'h4D, 8'h61, 8'h6E,
                   8'h80, 8'h01});
        send_msg('{8'h80, 8'h7F, 8'h55, 8'hAA});
    endtask

    task automatic test_no_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_random_msgs(85);
    endtask

    task automatic test_source_gaps();
        src_idle_pct   = 60;
        sink_stall_pct = 0;
        send_random_msgs(80);
    endtask

    task automatic test_sink_stall();
        src_idle_pct   = 0;
        sink_stall_pct = 60;
        send_random_msgs(80);
    endtask

    task automatic test_mixed_idle();
        src_idle_pct   = 22;
        sink_stall_pct = 22;
        send_random_msgs(80);
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] exp_ch,
                                 input logic exp_last);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected char %h last %b, got char %h last %b",
                     what, exp_ch, exp_last, m_tdata, m_tlast);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_text.size() == 0) begin
                note_mismatch("unexpected item", 8'h00, 1'b0);
            end else begin
                want = pending_text.pop_front();
                if (m_tdata !== want.ch)
                    note_mismatch("out_char", want.ch, want.last);
                if (m_tlast !== want.last)
                    note_mismatch("last_char", want.ch, want.last);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout with %0d chars outstanding", pending_text.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_no_idle();
        test_source_gaps();
        test_sink_stall();
        test_mixed_idle();

        s_tvalid <= 1'b0;
        while (pending_text.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/b64e_pkg.sv
rtl/core/b64e_front.sv
rtl/core/b64e_queue.sv
rtl/core/b64e_back.sv
rtl/core/base64_stream_encoder_top.sv
bench/tb_base64_stream_encoder_top.sv
